### src/assert_macros.svh
// Assertion macros shared by the scan unit RTL.
// Uses the clk and rst_n names of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define MBPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset.
`define MBPS_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MBPS_ASSERT(label, prop, msg)
`define MBPS_NEVER(label, expr, msg)
`endif
`endif

### src/mbps_pkg.sv
// Package for the masked byte pattern scan unit: sizes, mode codes,
// register indexes and the per-cell configuration struct. No dependencies.
package mbps_pkg;

    localparam int MaxPatternBytes = 16;
    localparam int MaxExtractBytes = 8;

    localparam int ByteW    = 8;
    localparam int ValueW   = 64;
    localparam int PatWordW = 64;
    localparam int ModesW   = 32;
    localparam int LenW     = 5;
    localparam int CfgDataW = 64;
    localparam int CfgIdxW  = 2;
    localparam int ModeW    = 2;

    localparam int PosW   = (MaxPatternBytes > 1) ? $clog2(MaxPatternBytes) : 1;
    localparam int CountW = $clog2(MaxPatternBytes + 1);
    localparam int SlotW  = (MaxExtractBytes > 1) ? $clog2(MaxExtractBytes) : 1;

    // Position modes; the fourth code acts as ignore.
    localparam logic [ModeW-1:0] MODE_COMPARE = 2'd0;
    localparam logic [ModeW-1:0] MODE_EXTRACT = 2'd1;
    localparam logic [ModeW-1:0] MODE_IGNORE  = 2'd2;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_MODES        = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_LENGTH       = 2'd3;

    // What one window cell checks against and where its byte lands.
    typedef struct packed {
        logic             cmp;
        logic             ext;
        logic [ByteW-1:0] pat;
        logic [SlotW-1:0] slot;
    } lane_cfg_t;

endpackage

### src/mbps_if.sv
// Channel interfaces of the scan unit: byte input and result output.
// Depends on mbps_pkg.
interface mbps_scan_if;
    import mbps_pkg::*;
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] data_byte;
    logic             region_end;

    modport source (output valid, data_byte, region_end, input ready);
    modport sink   (input valid, data_byte, region_end, output ready);
endinterface

interface mbps_result_if;
    import mbps_pkg::*;
    logic              valid;
    logic              ready;
    logic              found;
    logic [ValueW-1:0] extracted_value;

    modport source (output valid, found, extracted_value, input ready);
    modport sink   (input valid, found, extracted_value, output ready);
endinterface

### src/mbps_lane_cfg.sv
// Decodes the pattern registers into one configuration per window cell.
// Depends on mbps_pkg.
module mbps_lane_cfg (
    input  logic [mbps_pkg::PatWordW-1:0] pattern_low,
    input  logic [mbps_pkg::PatWordW-1:0] pattern_high,
    input  logic [mbps_pkg::ModesW-1:0]   modes,
    input  logic [mbps_pkg::LenW-1:0]     length,
    output mbps_pkg::lane_cfg_t           lanes [mbps_pkg::MaxPatternBytes],
    output logic [mbps_pkg::CountW-1:0]   len_eff
);
    import mbps_pkg::*;

    logic [2*PatWordW-1:0]      pat_all;
    logic [ByteW-1:0]           pat_bytes [MaxPatternBytes];
    logic [ModeW-1:0]           pos_mode  [MaxPatternBytes];
    logic [MaxPatternBytes-1:0] ext_mask;
    logic [CountW-1:0]          prefix    [MaxPatternBytes];

    assign pat_all = {pattern_high, pattern_low};

    // Clamp length to 1..MaxPatternBytes.
    always_comb
    begin
        priority if (length == '0)
        begin
            len_eff = CountW'(1);
        end
        else if (length > LenW'(MaxPatternBytes))
        begin
            len_eff = CountW'(MaxPatternBytes);
        end
        else
        begin
            len_eff = CountW'(length);
        end
    end

    for (genvar p = 0; p < MaxPatternBytes; p++)
    begin : g_pos
        localparam logic [MaxPatternBytes-1:0] LowMask = MaxPatternBytes'((1 << p) - 1);
        assign pat_bytes[p] = pat_all[ByteW*p +: ByteW];
        assign pos_mode[p]  = modes[ModeW*p +: ModeW];
        assign ext_mask[p]  = (pos_mode[p] == MODE_EXTRACT);
        // Wildcards below this position set its byte slot in the value.
        assign prefix[p]    = CountW'($countones(ext_mask & LowMask));
    end

    // Cell k holds pattern position k + len - MaxPatternBytes when in range.
    for (genvar k = 0; k < MaxPatternBytes; k++)
    begin : g_lane
        logic [CountW:0] sum;
        logic            active;
        logic [PosW-1:0] pos;

        assign sum    = (CountW+1)'(k) + (CountW+1)'(len_eff);
        assign active = (sum >= (CountW+1)'(MaxPatternBytes));
        assign pos    = PosW'(sum - (CountW+1)'(MaxPatternBytes));

        assign lanes[k].cmp  = active && (pos_mode[pos] == MODE_COMPARE);
        assign lanes[k].ext  = active && ext_mask[pos]
                               && (prefix[pos] < CountW'(MaxExtractBytes));
        assign lanes[k].pat  = pat_bytes[pos];
        assign lanes[k].slot = SlotW'(prefix[pos]);
    end

endmodule

### src/mbps_cell.sv
// One window cell: holds a byte, passes it on, checks the byte entering it.
// Depends on mbps_pkg.
module mbps_cell (
    input  logic                        clk,
    input  logic                        shift,
    input  logic [mbps_pkg::ByteW-1:0]  d_in,
    input  mbps_pkg::lane_cfg_t         lane,
    output logic [mbps_pkg::ByteW-1:0]  q,
    output logic                        ok,
    output logic [mbps_pkg::ValueW-1:0] ext_val
);
    import mbps_pkg::*;

    logic [ByteW-1:0] q_reg;
    logic [ByteW-1:0] q_next;

    assign q_next = shift ? d_in : q_reg;

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

    // Check the byte this cell takes on the shift, not the one it holds.
    assign ok      = !lane.cmp || (d_in == lane.pat);
    assign ext_val = lane.ext ? (ValueW'(d_in) << (lane.slot * ByteW)) : '0;

endmodule

### src/masked_byte_pattern_scan_unit.sv
// Top level of the masked byte pattern scan unit.
// Depends on mbps_pkg, mbps_if, mbps_lane_cfg, mbps_cell and assert_macros.svh.
//
// Usage:
//   scan   - one region byte per transaction, region_end set on the last.
//   result - at most one transaction per region: found=1 with the packed
//            wildcard bytes on the first matching window, or found=0 and
//            value 0 on the region_end byte when nothing matched.
//   cfg    - write port (cfg_we, cfg_index, cfg_wdata); write only while idle.
// Timing:
//   One byte per cycle. A row of 16 window cells shifts once per accepted
//   byte and each cell compares the byte it takes in the same cycle, so a
//   result is loaded into the output register as its byte is accepted.
//   The output register is refilled in the cycle it is taken, so a byte
//   is accepted every cycle while the receiver keeps up.
// Stall:
//   While a result waits and result.ready is low, scan.ready is low; the
//   result holds until taken.
// Reset:
//   Clears the region state and the output valid, loads pattern length 1 and
//   zero into the other config registers. Window cells keep stale bytes.
module masked_byte_pattern_scan_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    mbps_scan_if.sink                      scan,
    mbps_result_if.source                  result,
    input  logic                           cfg_we,
    input  logic [mbps_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [mbps_pkg::CfgDataW-1:0]  cfg_wdata
);
    import mbps_pkg::*;

    // Configuration registers
    logic [PatWordW-1:0] pat_low_reg;
    logic [PatWordW-1:0] pat_high_reg;
    logic [ModesW-1:0]   modes_reg;
    logic [LenW-1:0]     length_reg;

    // Region state
    logic [CountW-1:0] bytes_seen_reg;
    logic [CountW-1:0] bytes_seen_next;
    logic              matched_reg;
    logic              matched_next;

    // Output register
    logic              result_valid_reg;
    logic              result_valid_next;
    logic              found_reg;
    logic              found_next;
    logic [ValueW-1:0] value_reg;
    logic [ValueW-1:0] value_next;

    // Cell row
    lane_cfg_t            lanes    [MaxPatternBytes];
    logic [CountW-1:0]    len_eff;
    logic [ByteW-1:0]     cell_in  [MaxPatternBytes];
    logic [ByteW-1:0]     cell_q   [MaxPatternBytes];
    logic [ValueW-1:0]    cell_ext [MaxPatternBytes];
    logic [MaxPatternBytes-1:0] cell_ok;

    logic              scan_acc;
    logic [CountW-1:0] seen_inc;
    logic              window_full;
    logic              hit;
    logic              emit;
    logic [ValueW-1:0] ext_or;

    //------------------------------------------------------------------
    // Configuration writes
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            modes_reg    <= '0;
            length_reg   <= LenW'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pat_low_reg  <= cfg_wdata[PatWordW-1:0];
                REG_PATTERN_HIGH: pat_high_reg <= cfg_wdata[PatWordW-1:0];
                REG_MODES:        modes_reg    <= cfg_wdata[ModesW-1:0];
                REG_LENGTH:       length_reg   <= cfg_wdata[LenW-1:0];
            endcase
        end
    end

    mbps_lane_cfg u_lane_cfg (
        .pattern_low  (pat_low_reg),
        .pattern_high (pat_high_reg),
        .modes        (modes_reg),
        .length       (length_reg),
        .lanes        (lanes),
        .len_eff      (len_eff)
    );

    //------------------------------------------------------------------
    // Window: cell MaxPatternBytes-1 takes the new byte, each cell
    // hands its byte to the lower neighbor on every accepted transaction.
    //------------------------------------------------------------------
    assign scan_acc   = scan.valid && scan.ready;
    assign scan.ready = !result_valid_reg || result.ready;

    for (genvar k = 0; k < MaxPatternBytes; k++)
    begin : g_cell
        if (k == MaxPatternBytes - 1)
        begin : g_head
            assign cell_in[k] = scan.data_byte;
        end
        else
        begin : g_body
            assign cell_in[k] = cell_q[k+1];
        end

        mbps_cell u_cell (
            .clk     (clk),
            .shift   (scan_acc),
            .d_in    (cell_in[k]),
            .lane    (lanes[k]),
            .q       (cell_q[k]),
            .ok      (cell_ok[k]),
            .ext_val (cell_ext[k])
        );
    end

    // Wildcard slots are disjoint, so the packed value is a plain OR.
    always_comb
    begin
        ext_or = '0;
        for (int k = 0; k < MaxPatternBytes; k++)
        begin
            ext_or = ext_or | cell_ext[k];
        end
    end

    //------------------------------------------------------------------
    // Region control and output register
    //------------------------------------------------------------------
    // Saturate the byte count at the window depth.
    assign seen_inc    = (bytes_seen_reg == CountW'(MaxPatternBytes)) ?
                         bytes_seen_reg : bytes_seen_reg + CountW'(1);
    assign window_full = (seen_inc >= len_eff);
    assign hit         = !matched_reg && window_full && (&cell_ok);
    // After a match the rest of the region stays silent.
    assign emit        = !matched_reg && (hit || scan.region_end);

    always_comb
    begin
        bytes_seen_next   = bytes_seen_reg;
        matched_next      = matched_reg;
        result_valid_next = result_valid_reg;
        found_next        = found_reg;
        value_next        = value_reg;

        if (result_valid_reg && result.ready)
        begin
            result_valid_next = 1'b0;
        end

        if (scan_acc)
        begin
            bytes_seen_next = seen_inc;
            matched_next    = matched_reg || hit;
            if (scan.region_end)
            begin
                // Start the next region from scratch.
                bytes_seen_next = '0;
                matched_next    = 1'b0;
            end
            if (emit)
            begin
                result_valid_next = 1'b1;
                found_next        = hit;
                value_next        = hit ? ext_or : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg   <= '0;
            matched_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            bytes_seen_reg   <= bytes_seen_next;
            matched_reg      <= matched_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        value_reg <= value_next;
    end

    assign result.valid           = result_valid_reg;
    assign result.found           = found_reg;
    assign result.extracted_value = value_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
`include "assert_macros.svh"

    `MBPS_ASSERT(a_zero_on_miss, result_valid_reg && !found_reg |-> value_reg == '0, "no-match result carries a value")
    `MBPS_NEVER(a_seen_bound, bytes_seen_reg > CountW'(MaxPatternBytes), "byte count past window depth")
    `MBPS_ASSERT(a_region_clear, scan_acc && scan.region_end |=> bytes_seen_reg == '0 && !matched_reg, "region state not cleared at region end")
    `MBPS_ASSERT(a_match_reported, $rose(matched_reg) |-> result_valid_reg && found_reg, "match taken without a found result")

endmodule

### bench/tb_masked_byte_pattern_scan_unit.sv
// Self-checking bench for masked_byte_pattern_scan_unit.
// Depends on mbps_pkg, mbps_if and the scan unit RTL. It predicts every
// result itself and runs directed regions first, then random regions.
`timescale 1ns / 100ps

module tb_masked_byte_pattern_scan_unit;
    import mbps_pkg::*;

    // The fourth mode code is not named in the package; it acts as ignore.
    localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;

    localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
    localparam int LONG_HOLD      = 300;   // receiver hold-off, in cycles
    localparam int SETTLE_CYCLES  = 4;     // lets the output register settle
    localparam int RANDOM_TARGET  = 1750;  // bytes queued in the random part
    localparam int PHASE_BYTES    = 150;   // bytes per configuration phase
    localparam int MAX_REPORTS    = 10;

    // Region shapes for the random part.
    localparam int REGION_MATCH  = 0;
    localparam int REGION_BROKEN = 1;
    localparam int REGION_NOISE  = 2;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             last;
    } scan_byte_t;

    typedef struct packed {
        logic              found;
        logic [ValueW-1:0] value;
    } scan_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Every block input starts at a known value; the bench drives these.
    logic                drv_valid      = 1'b0;
    logic [ByteW-1:0]    drv_data       = '0;
    logic                drv_region_end = 1'b0;
    logic                drv_ready      = 1'b0;
    logic                drv_cfg_we     = 1'b0;
    logic [CfgIdxW-1:0]  drv_cfg_index  = REG_PATTERN_LOW;
    logic [CfgDataW-1:0] drv_cfg_wdata  = '0;

    mbps_scan_if   scan_ch ();
    mbps_result_if result_ch ();

    assign scan_ch.valid      = drv_valid;
    assign scan_ch.data_byte  = drv_data;
    assign scan_ch.region_end = drv_region_end;
    assign result_ch.ready    = drv_ready;

    masked_byte_pattern_scan_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan      (scan_ch.sink),
        .result    (result_ch.source),
        .cfg_we    (drv_cfg_we),
        .cfg_index (drv_cfg_index),
        .cfg_wdata (drv_cfg_wdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    scan_byte_t   bytes_to_send [$];     // filled by the stimulus, drained by the driver
    scan_result_t expected_results [$];  // oldest prediction at the front

    bit idle_on       = 1'b1;  // random gaps on both sides when set
    bit long_hold_req = 1'b0;  // ask the receiver for one long hold-off
    bit scan_taken    = 1'b0;  // set at the edge that accepts a byte
    bit result_taken  = 1'b0;  // set at the edge that accepts a result
    bit scan_live     = 1'b0;  // driver is offering a byte

    int mismatches = 0;
    int quiet_cycles = 0;
    int queued = 0;

    // Configuration the stimulus is currently shaping regions for.
    logic [PatWordW-1:0] ph_low   = '0;
    logic [PatWordW-1:0] ph_high  = '0;
    logic [ModesW-1:0]   ph_modes = '0;
    logic [LenW-1:0]     ph_len   = 5'd1;

    // ------------------------------------------------------------------
    // Scan predictor: its own copy of registers and region state
    // ------------------------------------------------------------------
    logic [PatWordW-1:0] cfg_pat_low  = '0;
    logic [PatWordW-1:0] cfg_pat_high = '0;
    logic [ModesW-1:0]   cfg_modes    = '0;
    logic [LenW-1:0]     cfg_len      = 5'd1;

    logic [ByteW-1:0] win_bytes [MaxPatternBytes];
    int               region_count = 0;  // saturates at MaxPatternBytes
    bit               region_hit   = 1'b0;

    initial begin
        foreach (win_bytes[k]) win_bytes[k] = '0;
    end

    // Shift one accepted byte into the window and queue whatever it causes.
    task automatic predict_scan(input logic [ByteW-1:0] b, input logic last);
        int                         len;
        int                         base;
        bit                         ok;
        logic [ValueW-1:0]          val;
        logic [ModeW-1:0]           md;
        logic [2*PatWordW-1:0]      pat;
        scan_result_t               res;
        pat = {cfg_pat_high, cfg_pat_low};
        if (!region_hit) begin
            // Clamp the length: zero acts as one, anything past 16 as 16.
            len = int'(cfg_len);
            if (len == 0) len = 1;
            if (len > MaxPatternBytes) len = MaxPatternBytes;

            for (int j = 0; j < MaxPatternBytes - 1; j++)
                win_bytes[j] = win_bytes[j + 1];
            win_bytes[MaxPatternBytes - 1] = b;
            if (region_count < MaxPatternBytes) region_count++;

            if (region_count >= len) begin
                base = MaxPatternBytes - len;
                ok   = 1'b1;
                for (int i = 0; i < len; i++) begin
                    md = cfg_modes[2*i +: 2];
                    if (md == MODE_COMPARE && win_bytes[base + i] != pat[8*i +: 8])
                        ok = 1'b0;
                end
                if (ok) begin
                    // Pack from the highest position down; shifting out the top
                    // keeps only the lowest-positioned eight wildcards.
                    val = '0;
                    for (int i = len - 1; i >= 0; i--) begin
                        md = cfg_modes[2*i +: 2];
                        if (md == MODE_EXTRACT)
                            val = {val[ValueW-ByteW-1:0], win_bytes[base + i]};
                    end
                    region_hit = 1'b1;
                    res.found  = 1'b1;
                    res.value  = val;
                    expected_results.push_back(res);
                end
            end

            // Region closes without a match: report found 0.
            if (last && !region_hit) begin
                res.found = 1'b0;
                res.value = '0;
                expected_results.push_back(res);
            end
        end
        if (last) begin
            foreach (win_bytes[k]) win_bytes[k] = '0;
            region_count = 0;
            region_hit   = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample at the rising edge, predict, compare, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        scan_result_t want;
        bit           progress;
        if (rst_n) begin
            progress = 1'b0;

            // Mirror register writes; a byte accepted at this edge already sees them.
            if (drv_cfg_we) begin
                case (drv_cfg_index)
                    REG_PATTERN_LOW:  cfg_pat_low  = drv_cfg_wdata;
                    REG_PATTERN_HIGH: cfg_pat_high = drv_cfg_wdata;
                    REG_MODES:        cfg_modes    = drv_cfg_wdata[ModesW-1:0];
                    REG_LENGTH:       cfg_len      = drv_cfg_wdata[LenW-1:0];
                    default:          ;
                endcase
            end

            // Predict first: a result taken at this edge belongs to an older
            // byte, so it still sits ahead in the queue.
            if (scan_ch.valid && scan_ch.ready) begin
                predict_scan(scan_ch.data_byte, scan_ch.region_end);
                scan_taken = 1'b1;
                progress   = 1'b1;
            end

            if (result_ch.valid && result_ch.ready) begin
                result_taken = 1'b1;
                progress     = 1'b1;
                if (expected_results.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%t unexpected result: found %0d value %h", $realtime,
                                 result_ch.found, result_ch.extracted_value);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.found !== result_ch.found ||
                        want.value !== result_ch.extracted_value) begin
                        if (mismatches < MAX_REPORTS)
                            $display("%t mismatch: found exp %0d got %0d, value exp %h got %h",
                                     $realtime, want.found, result_ch.found,
                                     want.value, result_ch.extracted_value);
                        mismatches++;
                    end
                end
            end

            // Count cycles with no transaction on either side.
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%t watchdog: no transaction for %0d cycles", $realtime,
                         WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer bytes from the queue at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        int         scan_gap;
        scan_byte_t cur;
        if (rst_n) begin
            // Drop the byte once accepted and draw the pause before the next.
            if (scan_taken) begin
                scan_taken = 1'b0;
                scan_live  = 1'b0;
                scan_gap   = idle_on ? $urandom_range(0, 3) : 0;
            end
            if (!scan_live) begin
                if (scan_gap > 0)
                    scan_gap--;
                else if (bytes_to_send.size() > 0) begin
                    cur       = bytes_to_send.pop_front();
                    scan_live = 1'b1;
                end
            end
            // Single assignment per edge so valid stays high across back-to-back bytes.
            drv_valid      <= scan_live;
            drv_data       <= cur.data;
            drv_region_end <= cur.last;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: per-result pauses plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        int rx_gap;
        int rx_hold;
        if (rst_n) begin
            if (result_taken) begin
                result_taken = 1'b0;
                rx_gap       = idle_on ? $urandom_range(0, 3) : 0;
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rx_hold       = LONG_HOLD;
            end
            drv_ready <= (rx_hold == 0 && rx_gap == 0);
            if (rx_hold > 0)
                rx_hold--;
            else if (rx_gap > 0)
                rx_gap--;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [ByteW-1:0] b, input logic last);
        scan_byte_t item;
        item.data = b;
        item.last = last;
        bytes_to_send.push_back(item);
    endtask

    // Wait until every byte is taken and every result is in, then let the
    // output register settle before touching the registers.
    task automatic wait_idle();
        while (bytes_to_send.size() != 0 || scan_live || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers, one per cycle, while the block is idle.
    task automatic write_config(input logic [CfgDataW-1:0] low, high, modes, len);
        ph_low   = low;
        ph_high  = high;
        ph_modes = modes[ModesW-1:0];
        ph_len   = len[LenW-1:0];
        @(negedge clk);
        drv_cfg_we    <= 1'b1;
        drv_cfg_index <= REG_PATTERN_LOW;
        drv_cfg_wdata <= low;
        @(negedge clk);
        drv_cfg_index <= REG_PATTERN_HIGH;
        drv_cfg_wdata <= high;
        @(negedge clk);
        drv_cfg_index <= REG_MODES;
        drv_cfg_wdata <= modes;
        @(negedge clk);
        drv_cfg_index <= REG_LENGTH;
        drv_cfg_wdata <= len;
        @(negedge clk);
        drv_cfg_we <= 1'b0;
    endtask

    // Build one region for the current pattern. A match region carries a
    // conforming window between random bytes; a broken one has one window
    // byte spoiled; noise is just random bytes.
    task automatic queue_region(input int kind);
        logic [2*PatWordW-1:0] pat;
        logic [ModeW-1:0]      md;
        logic [ByteW-1:0]      body [$];
        int                    len;
        int                    n;
        int                    flip;
        pat = {ph_high, ph_low};
        len = int'(ph_len);
        if (len == 0) len = 1;
        if (len > MaxPatternBytes) len = MaxPatternBytes;
        if (kind == REGION_NOISE) begin
            n = $urandom_range(1, 20);
            repeat (n) body.push_back(ByteW'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(0, 5);
            repeat (n) body.push_back(ByteW'($urandom_range(0, 255)));
            for (int i = 0; i < len; i++) begin
                md = ph_modes[2*i +: 2];
                if (md == MODE_COMPARE)
                    body.push_back(pat[8*i +: 8]);
                else
                    body.push_back(ByteW'($urandom_range(0, 255)));
            end
            if (kind == REGION_BROKEN) begin
                flip = body.size() - len + $urandom_range(0, len - 1);
                body[flip] = body[flip] ^ ByteW'($urandom_range(1, 255));
            end
            n = $urandom_range(0, 4);
            repeat (n) body.push_back(ByteW'($urandom_range(0, 255)));
        end
        foreach (body[k]) push_byte(body[k], k == body.size() - 1);
        queued += body.size();
    endtask

    // Draw position modes: half compare, a quarter extract, the odd ignore and spare code.
    function automatic logic [ModesW-1:0] draw_modes();
        logic [ModesW-1:0] m;
        int                r;
        for (int i = 0; i < MaxPatternBytes; i++) begin
            r = $urandom_range(0, 7);
            if (r < 4)       m[2*i +: 2] = MODE_COMPARE;
            else if (r < 6)  m[2*i +: 2] = MODE_EXTRACT;
            else if (r == 6) m[2*i +: 2] = MODE_IGNORE;
            else             m[2*i +: 2] = MODE_SPARE;
        end
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [CfgDataW-1:0] low, high, modes, len;
        int                  phase;
        int                  phase_start;
        int                  r;

        // Hold reset, then release it at a falling edge, away from the rising edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration: length 1, pattern byte 0x00, compare.
        push_byte(8'h00, 1'b0);  // match on the first byte
        push_byte(8'h55, 1'b1);  // ignored after the match, region end is silent
        push_byte(8'hFF, 1'b1);  // no match: found 0
        wait_idle();

        // DE AD, extract, spare code (acts as ignore); length 4.
        modes = '0;
        modes[1:0] = MODE_COMPARE;
        modes[3:2] = MODE_COMPARE;
        modes[5:4] = MODE_EXTRACT;
        modes[7:6] = MODE_SPARE;
        write_config(64'h0000_0000_3412_ADDE, 64'h0, modes, 64'd4);
        push_byte(8'hDE, 1'b0);  // short region: no full window
        push_byte(8'hAD, 1'b1);
        push_byte(8'h11, 1'b0);  // match lands on the region_end byte
        push_byte(8'hDE, 1'b0);
        push_byte(8'hAD, 1'b0);
        push_byte(8'h77, 1'b0);
        push_byte(8'h88, 1'b1);
        push_byte(8'hDE, 1'b0);  // match mid-region, tail ignored
        push_byte(8'hAD, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h03, 1'b1);
        wait_idle();

        // Length zero acts as one; single wildcard; junk in upper data bits.
        modes = {32'hFFFF_FFFF, 32'h0000_0001};
        write_config(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, modes, 64'hFFFF_FFFF_FFFF_FFE0);
        push_byte(8'hA5, 1'b1);
        wait_idle();

        // Ten wildcards: only the lowest eight positions survive packing.
        write_config(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0005_5555, 64'd10);
        for (int i = 1; i <= 10; i++) push_byte(i[ByteW-1:0], i == 10);
        wait_idle();

        // Random phases, the first few pinned to the register extremes.
        phase = 0;
        while (queued < RANDOM_TARGET) begin
            low  = {$urandom, $urandom};
            high = {$urandom, $urandom};
            modes = {$urandom, draw_modes()};
            r = $urandom_range(0, 9);
            if (r < 8)       len = {$urandom, 27'($urandom), 5'($urandom_range(1, 16))};
            else if (r == 8) len = {$urandom, 27'($urandom), 5'd0};
            else             len = {$urandom, 27'($urandom), 5'($urandom_range(17, 31))};
            case (phase)
                0: begin  // longest pattern, every position compared
                    modes = '0;
                    len   = 64'd16;
                end
                1: begin  // one position, pattern all ones
                    low  = '1;
                    high = '1;
                    len  = 64'd1;
                end
                2: begin  // two wildcards, dense results; receiver holds off
                    modes = 64'h5;
                    len   = 64'd2;
                end
                3: begin  // sixteen wildcards
                    modes = 64'h5555_5555;
                    len   = 64'd16;
                end
                4: begin  // length past the maximum, every position spare code
                    modes = 64'hFFFF_FFFF;
                    len   = 64'd31;
                end
                5: len = 64'd0;
                default: ;
            endcase
            write_config(low, high, modes, len);

            // Every third phase runs with no idling on either side.
            idle_on = (phase % 3 != 1);
            if (phase == 2) long_hold_req = 1'b1;

            phase_start = queued;
            while (queued - phase_start < PHASE_BYTES) begin
                r = $urandom_range(0, 9);
                if (r < 7)      queue_region(REGION_MATCH);
                else if (r < 8) queue_region(REGION_BROKEN);
                else            queue_region(REGION_NOISE);
            end
            wait_idle();
            phase++;
        end

        // Drain, then give a stray result time to show up.
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
